// File: design/ldsol_pkg.sv
`timescale 1ns / 1ps

package ldsol_pkg;

  localparam int COEF_FIELD_W = 16;
  localparam int RHS_W        = 16;
  localparam int SOL_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int COEF_WIDTH_DEF = 16;

  localparam logic [STATUS_W-1:0] ST_SOLVED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SOL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;

  typedef struct packed {
    logic [COEF_FIELD_W-1:0] coef_a;
    logic [COEF_FIELD_W-1:0] coef_b;
    logic signed [RHS_W-1:0] rhs;
  } ldsol_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [COEF_FIELD_W-1:0] divisor;
    logic signed [SOL_W-1:0] sol_x;
    logic signed [SOL_W-1:0] sol_y;
    logic [COEF_FIELD_W-1:0] step_x;
    logic [COEF_FIELD_W-1:0] step_y;
  } ldsol_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ldsol_div_stat_t;

endpackage

// File: design/ldsol_chan_if.sv
`timescale 1ns / 1ps

interface ldsol_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/ldsol_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module ldsol_div import ldsol_pkg::*; #(
  parameter int DIV_W = COEF_FIELD_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output ldsol_div_stat_t  stat,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dvs;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] rem_diff;
  logic           ge;

  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign ge       = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: design/ldsol_mul.sv
`timescale 1ns / 1ps

// Signed multiplier with the product registered.
module ldsol_mul import ldsol_pkg::*; #(
  parameter int A_W = COEF_WIDTH_DEF + 1,
  parameter int B_W = RHS_W + 1
) (
  input  logic                       clk,
  input  logic signed [A_W-1:0]      op_a,
  input  logic signed [B_W-1:0]      op_b,
  output logic signed [A_W+B_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// File: design/linear_diophantine_solver.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                                        Transfer
// eqn      in   coef_a, coef_b, rhs                            valid & ready
// result   out  status, divisor, sol_x, sol_y, step_x, step_y  valid & ready
//
// One equation at a time. Both coefficients zero go straight to the result. Otherwise
// each Euclid step runs the bit-serial divider and two multiply-subtract steps; then
// rhs magnitude is divided by the gcd and, if exact, two products give the solution.
// Reset is synchronous and clears the sequencer, divider and result valid.
// eqn is accepted whenever the sequencer is idle, even while a result waits;
// a stalled result holds the finished item until it is taken.
module linear_diophantine_solver import ldsol_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ldsol_chan_if.sink   eqn,
  ldsol_chan_if.source result
);

  localparam int COEF_W = (COEF_WIDTH < COEF_FIELD_W) ? COEF_WIDTH : COEF_FIELD_W;
  localparam int DIV_W  = (COEF_W > RHS_W) ? COEF_W : RHS_W;
  localparam int A_W    = COEF_W + 1;
  localparam int B_W    = RHS_W + 1;
  localparam int PW     = A_W + B_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EUC  = 4'd1;
  localparam logic [3:0] S_EDIV = 4'd2;
  localparam logic [3:0] S_MV   = 4'd3;
  localparam logic [3:0] S_MW   = 4'd4;
  localparam logic [3:0] S_CDIV = 4'd5;
  localparam logic [3:0] S_XM   = 4'd6;
  localparam logic [3:0] S_YM   = 4'd7;
  localparam logic [3:0] S_YW   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state;

  logic [COEF_W-1:0]       p;
  logic [COEF_W-1:0]       q;
  logic [COEF_W-1:0]       k;
  logic signed [A_W-1:0]   u;
  logic signed [A_W-1:0]   up;
  logic signed [A_W-1:0]   v;
  logic signed [A_W-1:0]   vp;
  logic signed [RHS_W-1:0] c;
  logic signed [B_W-1:0]   cq;
  logic [COEF_W-1:0]       d;
  logic [STATUS_W-1:0]     status;
  logic signed [SOL_W-1:0] sol_x;
  logic signed [SOL_W-1:0] sol_y;
  logic [COEF_FIELD_W-1:0] step_x;
  logic [COEF_FIELD_W-1:0] step_y;

  logic       out_valid;
  ldsol_out_t out_data;

  // divider
  logic            div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  ldsol_div_stat_t div_stat;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_rem;

  // multiplier
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic signed [PW-1:0]  prod;

  logic [RHS_W-1:0]        c_mag;
  logic signed [PW-1:0]    up_ext;
  logic signed [PW-1:0]    vp_ext;
  logic signed [PW-1:0]    u_diff;
  logic signed [PW-1:0]    v_diff;
  logic signed [A_W-1:0]   u_neg;
  logic signed [A_W-1:0]   v_neg;
  logic [COEF_W-1:0]       u_abs;
  logic [COEF_W-1:0]       v_abs;
  logic [COEF_W-1:0]       a_in;
  logic [COEF_W-1:0]       b_in;
  logic signed [B_W-1:0]   cq_pos;
  logic                    in_xfer;
  logic                    out_load;

  assign a_in    = eqn.data.coef_a[COEF_W-1:0];
  assign b_in    = eqn.data.coef_b[COEF_W-1:0];
  assign in_xfer = eqn.valid && eqn.ready;
  assign out_load = (state == S_FIN) && (!out_valid || result.ready);

  assign c_mag  = c[RHS_W-1] ? RHS_W'(-c) : RHS_W'(c);
  assign up_ext = PW'(up);
  assign vp_ext = PW'(vp);
  assign u_diff = up_ext - prod;
  assign v_diff = vp_ext - prod;
  assign u_neg  = -u;
  assign v_neg  = -v;
  assign u_abs  = u[A_W-1] ? u_neg[COEF_W-1:0] : u[COEF_W-1:0];
  assign v_abs  = v[A_W-1] ? v_neg[COEF_W-1:0] : v[COEF_W-1:0];
  assign cq_pos = $signed({1'b0, div_quo[RHS_W-1:0]});

  // divider launch: Euclid step p/q, or rhs magnitude over the gcd once q hits zero
  assign div_start = (state == S_EUC);
  always_comb begin
    if (q == '0) begin
      div_dividend = DIV_W'(c_mag);
      div_divisor  = DIV_W'(p);
    end else begin
      div_dividend = DIV_W'(p);
      div_divisor  = DIV_W'(q);
    end
  end

  always_comb begin
    unique case (state)
      S_EDIV: begin
        mul_a = $signed({1'b0, div_quo[COEF_W-1:0]});
        mul_b = B_W'(u);
      end
      S_MV: begin
        mul_a = $signed({1'b0, k});
        mul_b = B_W'(v);
      end
      S_XM: begin
        mul_a = up;
        mul_b = cq;
      end
      default: begin
        mul_a = vp;
        mul_b = cq;
      end
    endcase
  end

  ldsol_div #(.DIV_W(DIV_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ldsol_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= ((a_in == '0) && (b_in == '0)) ? S_FIN : S_EUC;
          end
        end
        S_EUC:  state <= (q == '0) ? S_CDIV : S_EDIV;
        S_EDIV: if (div_stat.done) state <= S_MV;
        S_MV:   state <= S_MW;
        S_MW:   state <= S_EUC;
        S_CDIV: begin
          if (div_stat.done) begin
            state <= (div_rem != '0) ? S_FIN : S_XM;
          end
        end
        S_XM:   state <= S_YM;
        S_YM:   state <= S_YW;
        S_YW:   state <= S_FIN;
        S_FIN:  if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          p      <= a_in;
          q      <= b_in;
          c      <= eqn.data.rhs;
          up     <= A_W'(1);
          u      <= '0;
          vp     <= '0;
          v      <= A_W'(1);
          status <= ST_ZERO;
          d      <= '0;
          sol_x  <= '0;
          sol_y  <= '0;
          step_x <= '0;
          step_y <= '0;
        end
      end
      S_EUC: begin
        if (q == '0) d <= p;
      end
      S_EDIV: begin
        if (div_stat.done) begin
          k <= div_quo[COEF_W-1:0];
          p <= q;
          q <= div_rem[COEF_W-1:0];
        end
      end
      S_MV: begin
        u  <= u_diff[A_W-1:0];
        up <= u;
      end
      S_MW: begin
        v  <= v_diff[A_W-1:0];
        vp <= v;
      end
      S_CDIV: begin
        if (div_stat.done) begin
          if (div_rem != '0) begin
            status <= ST_NO_SOL;
          end else begin
            cq     <= c[RHS_W-1] ? -cq_pos : cq_pos;
            // final coefficients are the reduced coefficients up to sign
            step_x <= COEF_FIELD_W'(u_abs);
            step_y <= COEF_FIELD_W'(v_abs);
          end
        end
      end
      S_YM: sol_x <= SOL_W'(prod);
      S_YW: begin
        sol_y  <= SOL_W'(prod);
        status <= ST_SOLVED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.status  <= status;
      out_data.divisor <= COEF_FIELD_W'(d);
      out_data.sol_x   <= sol_x;
      out_data.sol_y   <= sol_y;
      out_data.step_x  <= step_x;
      out_data.step_y  <= step_y;
    end
  end

  assign eqn.ready    = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_data;

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state != S_IDLE))
    else $error("sequencer stayed idle after an accepted item");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_EDIV || state == S_CDIV))
    else $error("divider finished outside a wait state");

  a_solved_gcd: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.status == ST_SOLVED) |-> (result.data.divisor != '0))
    else $error("solved result with zero gcd");

endmodule

// File: test/tb_linear_diophantine_solver.sv
`timescale 1ns / 1ps

module tb_linear_diophantine_solver;
  import ldsol_pkg::*;

  localparam int COEF_W = COEF_WIDTH_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       eqn_valid    = 1'b0;
  ldsol_in_t  eqn_data     = '0;
  logic       result_ready = 1'b0;

  ldsol_chan_if #(.payload_t(ldsol_in_t))  eqn_ch ();
  ldsol_chan_if #(.payload_t(ldsol_out_t)) res_ch ();

  assign eqn_ch.valid = eqn_valid;
  assign eqn_ch.data  = eqn_data;
  assign res_ch.ready = result_ready;

  linear_diophantine_solver #(.COEF_WIDTH(COEF_W)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .eqn    (eqn_ch),
    .result (res_ch)
  );

  ldsol_in_t  pending_eqns[$];
  ldsol_out_t expected_solutions[$];
  int         mismatches = 0;
  int         eqn_count  = 0;
  bit         eqn_took   = 1'b0;
  bit         hold_off   = 1'b0;

  initial forever #4 clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Extended Euclid on the reduced coefficients, Bezout pair scaled by c/d.
  function automatic ldsol_out_t solve_eqn(ldsol_in_t e);
    longint a, b, c, d, p, q, r, k, tmp;
    longint up, u, vp, v;
    ldsol_out_t res;
    res = '0;
    a = longint'(e.coef_a) & ((longint'(1) << COEF_W) - 1);
    b = longint'(e.coef_b) & ((longint'(1) << COEF_W) - 1);
    c = longint'($signed(e.rhs));
    if (a == 0 && b == 0) begin
      res.status = ST_ZERO;
      return res;
    end
    p = a;
    q = b;
    while (q != 0) begin
      r = p % q;
      p = q;
      q = r;
    end
    d = p;
    res.divisor = d[15:0];
    if (c % d != 0) begin
      res.status = ST_NO_SOL;
      return res;
    end
    a = a / d;
    b = b / d;
    c = c / d;
    up = 1; u = 0; vp = 0; v = 1;
    p = a;
    q = b;
    while (q != 0) begin
      k = p / q;
      r = p % q;
      p = q;
      q = r;
      tmp = u; u = up - k * u; up = tmp;
      tmp = v; v = vp - k * v; vp = tmp;
    end
    res.status = ST_SOLVED;
    res.sol_x  = clamp32(up * c);
    res.sol_y  = clamp32(vp * c);
    res.step_x = b[15:0];
    res.step_y = a[15:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%08h want 0x%08h", name, got, want));
  endtask

  task automatic add_eqn(int a, int b, int rhs);
    ldsol_in_t e;
    e.coef_a = a[15:0];
    e.coef_b = b[15:0];
    e.rhs    = rhs[15:0];
    pending_eqns.insert(pending_eqns.size(), e);
  endtask

  function automatic int pick_coef();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(1, 15);
      2: return 65535 - $urandom_range(0, 15);
      3: return 1 << $urandom_range(0, 15);
      4: return $urandom_range(1, 255);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Either arbitrary coefficients, or coefficients sharing a factor g; rhs then either a multiple of g or arbitrary.
  task automatic add_random_eqn();
    int g, a, b, kmin, kmax, rhs;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      add_eqn(pick_coef(), pick_coef(), $urandom_range(0, 65535));
    end else begin
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4096) : $urandom_range(2, 64);
      a = g * $urandom_range(0, 65535 / g);
      b = g * $urandom_range(0, 65535 / g);
      if (mode < 8) begin
        kmin = -(32768 / g);
        kmax = 32767 / g;
        rhs  = g * (kmin + int'($urandom_range(0, kmax - kmin)));
      end else begin
        rhs = $urandom_range(0, 65535);
      end
      add_eqn(a, b, rhs);
    end
  endtask

  // Sender: bursts of transfers separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      eqn_valid <= 1'b0;
    end else begin
      if (eqn_took) begin
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap_left = 0;
            5, 6, 7:       gap_left = $urandom_range(1, 8);
            default:       gap_left = $urandom_range(10, 400);
          endcase
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        eqn_valid <= 1'b0;
      end else if (pending_eqns.size() != 0) begin
        eqn_valid <= 1'b1;
        eqn_data  <= pending_eqns[0];
      end else begin
        eqn_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternating ready and stall runs, plus the long hold-off.
  bit ready_phase = 1'b0;
  int run_left    = 0;

  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        ready_phase = !ready_phase;
        if (ready_phase)
          run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(500, 3000)
                                                 : $urandom_range(1, 40);
        else
          run_left = $urandom_range(0, 40);
      end else begin
        run_left--;
      end
      result_ready <= ready_phase && !hold_off;
    end
  end

  initial begin
    while (eqn_count < 200) @(posedge clk);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  // Input side: each equation transfer produces one expected solution.
  always @(posedge clk) begin
    eqn_took = 1'b0;
    if (!rst && eqn_ch.valid && eqn_ch.ready) begin
      expected_solutions.insert(expected_solutions.size(), solve_eqn(eqn_ch.data));
      void'(pending_eqns.pop_front());
      eqn_count++;
      eqn_took = 1'b1;
    end
  end

  always @(posedge clk) begin
    ldsol_out_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (expected_solutions.size() == 0) begin
        report_mismatch("result with no equation outstanding");
      end else begin
        want = expected_solutions.pop_front();
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("divisor", 32'(got.divisor), 32'(want.divisor));
        check_field("sol_x", got.sol_x, want.sol_x);
        check_field("sol_y", got.sol_y, want.sol_y);
        check_field("step_x", 32'(got.step_x), 32'(want.step_x));
        check_field("step_y", 32'(got.step_y), 32'(want.step_y));
      end
    end
  end

  initial begin
    add_eqn(0, 0, 0);
    add_eqn(0, 0, -32768);
    add_eqn(0, 0, 32767);
    add_eqn(0, 5, 10);
    add_eqn(0, 5, 7);
    add_eqn(7, 0, -21);
    add_eqn(65535, 0, 1);
    add_eqn(0, 65535, 0);
    add_eqn(65535, 65535, -32768);
    add_eqn(65535, 65534, 32767);
    add_eqn(46368, 28657, 1);
    add_eqn(28657, 46368, -32768);
    add_eqn(1, 1, 0);
    add_eqn(1, 0, -1);
    add_eqn(6, 4, 3);
    add_eqn(6, 4, -2);
    add_eqn(12, 18, -32766);
    add_eqn(32768, 16384, -32768);
    add_eqn(65535, 1, 32767);
    add_eqn(1, 65535, -1);
    add_eqn(40000, 50000, 30000);
    add_eqn(3, 5, 32767);
    repeat (1700) add_random_eqn();

    while (pending_eqns.size() != 0) @(posedge clk);
    while (expected_solutions.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #50000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
